/* hdl/tspr_pkg.sv */
`timescale 1ns / 1ps

package tspr_pkg;

    localparam logic [2:0] CMD_TILE    = 3'd0;
    localparam logic [2:0] CMD_NAME    = 3'd1;
    localparam logic [2:0] CMD_SPRITE  = 3'd2;
    localparam logic [2:0] CMD_PALETTE = 3'd3;
    localparam logic [2:0] CMD_RENDER  = 3'd4;

    localparam int TILE_BYTES    = 8192;
    localparam int NAME_DEPTH    = 1024;
    localparam int NAME_BYTES    = 960;
    localparam int SPRITE_BYTES  = 256;
    localparam int SPRITE_SLOTS  = 64;
    localparam int PALETTE_BYTES = 48;
    localparam int PALETTE_SLOTS = 16;
    localparam int PRIORITY_BIT  = 5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPR,
        ST_BG_TILE,
        ST_BG_PIX,
        ST_PAL_RD,
        ST_PAL_WAIT
    } state_t;

    typedef struct packed {
        logic        hit;
        logic        lo;
        logic [12:0] addr;
    } tile_fetch_t;

    typedef struct packed {
        logic [3:0] entry;
        logic [1:0] comp;
    } pal_split_t;

    // Where in the tile sheet a tile placed at (sx, sy) covers pixel (px, py).
    function automatic tile_fetch_t tile_fetch(input logic [7:0] tile,
                                               input logic [7:0] sx,
                                               input logic [7:0] sy,
                                               input logic [7:0] px,
                                               input logic [7:0] py,
                                               input logic [8:0] height);
        tile_fetch_t r;
        logic [7:0]  ty;
        logic [7:0]  tx;
        logic [7:0]  vx;
        logic [5:0]  vy;
        ty = py - sy;
        tx = px - sx;
        vx = {tile[4:0], tx[2:0]};
        vy = {tile[7:5], ty[2:0]};
        r.hit  = ({1'b0, sy} < height) && (py >= sy) && (ty < 8'd8)
                 && ({1'b0, py} < height) && (tx < 8'd8);
        r.lo   = tx[0];
        r.addr = {vy, vx[7:1]};
        return r;
    endfunction

    // Palette byte index into entry and colour component (index / 3 by reciprocal).
    function automatic pal_split_t pal_split(input logic [5:0] idx);
        pal_split_t  r;
        logic [11:0] prod;
        logic [5:0]  base;
        prod    = 12'(idx) * 12'd43;
        r.entry = prod[10:7];
        base    = 6'(r.entry) * 6'd3;
        r.comp  = 2'(idx - base);
        return r;
    endfunction

endpackage

/* hdl/tspr_ram.sv */
`timescale 1ns / 1ps

module tspr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/tile_sprite_pixel_renderer_core.sv */
`timescale 1ns / 1ps

// Tile and sprite pixel renderer. Write beats load the tile sheet, name table, sprite
// records and palette. A render beat runs the sprite scan, then the background and
// palette states; its pixel is registered on the output, and no new beat is taken until
// that register is loaded. Stalls on the output can hold the render in ST_PAL_WAIT. The
// sprite scan reads one sprite record per cycle, highest index first. The tile sheet byte
// for each record follows through the sprite record read and then the single tile sheet
// read port. After that, ST_BG_TILE, ST_BG_PIX, ST_PAL_RD and ST_PAL_WAIT fetch the
// background tile byte, make the layer choice and read the palette. After reset the block
// clears all its memories and holds stall high meanwhile. Configuration writes are taken
// at any time. They should only be made while no render is in flight.
module tile_sprite_pixel_renderer_core
    import tspr_pkg::*;
#(
    parameter int SCREEN_HEIGHT = 240,
    parameter int SPRITE_COUNT  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [12:0] store_index,
    input  logic [7:0]  store_data,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] pixel_color,
    output logic        drawn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int         SPR_CNT_W  = $clog2(SPRITE_COUNT + 2);
    localparam logic [8:0] HEIGHT     = 9'(SCREEN_HEIGHT);
    localparam logic [5:0] ROW_LIMIT  = 6'(SCREEN_HEIGHT / 8);
    localparam logic [6:0] SPR_LAST   = 7'(SPRITE_COUNT - 1);
    localparam logic [SPR_CNT_W-1:0] SPR_ISSUES = SPR_CNT_W'(SPRITE_COUNT);
    localparam logic [SPR_CNT_W-1:0] SPR_END    = SPR_CNT_W'(SPRITE_COUNT + 1);

    state_t state_reg, state_next;

    logic [12:0]          clr_cnt_reg;
    logic [SPR_CNT_W-1:0] spr_cnt_reg;
    logic                 s1_valid_reg, s2_valid_reg;
    logic                 out_valid_reg;
    logic [7:0]           scroll_h_reg, scroll_v_reg;

    logic [7:0]  px_reg, py_reg;
    logic        s2_hit_reg, s2_lo_reg, s2_prio_reg;
    logic [3:0]  hi_v_reg, lo_v_reg, bg_v_reg;
    logic        bg_hit_reg, bg_lo_reg;
    logic        pal_drawn_reg;
    logic [23:0] color_reg;
    logic        drawn_reg;

    logic        accept, clearing, issue, out_load;
    logic [7:0]  tile_rdata, name_rdata;
    logic [7:0]  spr_tile, spr_x, spr_y, spr_flags;
    logic [7:0]  pal_r, pal_g, pal_b;
    logic        tile_we, name_we;
    logic [12:0] tile_waddr, tile_raddr;
    logic [9:0]  name_waddr;
    logic [7:0]  wr_data;
    logic [3:0]  spr_we;
    logic [5:0]  spr_waddr, spr_raddr;
    logic [2:0]  pal_we;
    logic [3:0]  pal_waddr, pal_raddr;
    pal_split_t  pal_pos;
    tile_fetch_t spr_fetch, bg_fetch;
    logic [3:0]  nibble, final_v;
    logic [7:0]  row_sum, col_sum, bg_sx, bg_sy;
    logic [4:0]  bg_row, bg_col;

    assign accept    = in_valid && !in_stall;
    assign clearing  = (state_reg == ST_CLEAR);
    assign issue     = (state_reg == ST_SPR) && (spr_cnt_reg < SPR_ISSUES);
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_load  = (state_reg == ST_PAL_WAIT) && (!out_valid_reg || !out_stall);
    assign pixel_color = color_reg;
    assign drawn       = drawn_reg;

    // Background geometry follows from the latched pixel and the scroll registers.
    assign row_sum = py_reg + scroll_v_reg;
    assign col_sum = px_reg + scroll_h_reg;
    assign bg_row  = row_sum[7:3];
    assign bg_col  = col_sum[7:3];
    assign bg_sx   = {bg_col, 3'b000} - scroll_h_reg;
    assign bg_sy   = {bg_row, 3'b000} - scroll_v_reg;

    assign spr_fetch = tile_fetch(spr_tile, spr_x, spr_y, px_reg, py_reg, HEIGHT);
    assign bg_fetch  = tile_fetch(name_rdata, bg_sx, bg_sy, px_reg, py_reg, HEIGHT);
    assign pal_pos   = pal_split(store_index[5:0]);
    assign final_v   = (hi_v_reg != 4'd0) ? hi_v_reg :
                       (bg_v_reg != 4'd0) ? bg_v_reg : lo_v_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == 13'(TILE_BYTES - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (accept && cmd == CMD_RENDER)
                    state_next = ST_SPR;
            ST_SPR:
                if (spr_cnt_reg == SPR_END)
                    state_next = ST_BG_TILE;
            ST_BG_TILE:
                state_next = ST_BG_PIX;
            ST_BG_PIX:
                state_next = ST_PAL_RD;
            ST_PAL_RD:
                state_next = ST_PAL_WAIT;
            ST_PAL_WAIT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        wr_data    = clearing ? 8'd0 : store_data;
        tile_we    = clearing || (accept && cmd == CMD_TILE);
        tile_waddr = clearing ? clr_cnt_reg : store_index;
        name_we    = clearing || (accept && cmd == CMD_NAME
                                  && store_index < 13'(NAME_BYTES));
        name_waddr = clearing ? clr_cnt_reg[9:0] : store_index[9:0];
        spr_waddr  = clearing ? clr_cnt_reg[5:0] : store_index[7:2];
        spr_we     = 4'd0;
        if (clearing)
            spr_we = 4'hf;
        else if (accept && cmd == CMD_SPRITE && store_index < 13'(SPRITE_BYTES))
            spr_we[store_index[1:0]] = 1'b1;
        pal_waddr  = clearing ? clr_cnt_reg[3:0] : pal_pos.entry;
        pal_we     = 3'd0;
        if (clearing)
            pal_we = 3'b111;
        else if (accept && cmd == CMD_PALETTE && store_index < 13'(PALETTE_BYTES))
            pal_we[pal_pos.comp] = 1'b1;
        spr_raddr  = 6'(SPR_LAST - 7'(spr_cnt_reg));
        tile_raddr = (state_reg == ST_BG_TILE) ? bg_fetch.addr : spr_fetch.addr;
        pal_raddr  = final_v;
    end

    tspr_ram #(.WIDTH(8), .DEPTH(TILE_BYTES)) u_tile_ram (
        .clk(clk), .we(tile_we), .waddr(tile_waddr), .wdata(wr_data),
        .raddr(tile_raddr), .rdata(tile_rdata)
    );

    tspr_ram #(.WIDTH(8), .DEPTH(NAME_DEPTH)) u_name_ram (
        .clk(clk), .we(name_we), .waddr(name_waddr), .wdata(wr_data),
        .raddr({bg_row, bg_col}), .rdata(name_rdata)
    );

    tspr_ram #(.WIDTH(8), .DEPTH(SPRITE_SLOTS)) u_spr_tile_ram (
        .clk(clk), .we(spr_we[0]), .waddr(spr_waddr), .wdata(wr_data),
        .raddr(spr_raddr), .rdata(spr_tile)
    );

    tspr_ram #(.WIDTH(8), .DEPTH(SPRITE_SLOTS)) u_spr_x_ram (
        .clk(clk), .we(spr_we[1]), .waddr(spr_waddr), .wdata(wr_data),
        .raddr(spr_raddr), .rdata(spr_x)
    );

    tspr_ram #(.WIDTH(8), .DEPTH(SPRITE_SLOTS)) u_spr_y_ram (
        .clk(clk), .we(spr_we[2]), .waddr(spr_waddr), .wdata(wr_data),
        .raddr(spr_raddr), .rdata(spr_y)
    );

    tspr_ram #(.WIDTH(8), .DEPTH(SPRITE_SLOTS)) u_spr_flags_ram (
        .clk(clk), .we(spr_we[3]), .waddr(spr_waddr), .wdata(wr_data),
        .raddr(spr_raddr), .rdata(spr_flags)
    );

    tspr_ram #(.WIDTH(8), .DEPTH(PALETTE_SLOTS)) u_pal_r_ram (
        .clk(clk), .we(pal_we[0]), .waddr(pal_waddr), .wdata(wr_data),
        .raddr(pal_raddr), .rdata(pal_r)
    );

    tspr_ram #(.WIDTH(8), .DEPTH(PALETTE_SLOTS)) u_pal_g_ram (
        .clk(clk), .we(pal_we[1]), .waddr(pal_waddr), .wdata(wr_data),
        .raddr(pal_raddr), .rdata(pal_g)
    );

    tspr_ram #(.WIDTH(8), .DEPTH(PALETTE_SLOTS)) u_pal_b_ram (
        .clk(clk), .we(pal_we[2]), .waddr(pal_waddr), .wdata(wr_data),
        .raddr(pal_raddr), .rdata(pal_b)
    );

    assign nibble = (state_reg == ST_BG_PIX) ?
                    (bg_lo_reg ? tile_rdata[3:0] : tile_rdata[7:4]) :
                    (s2_lo_reg ? tile_rdata[3:0] : tile_rdata[7:4]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= 13'd0;
            spr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            scroll_h_reg  <= 8'd0;
            scroll_v_reg  <= 8'd0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clearing ? clr_cnt_reg + 13'd1 : clr_cnt_reg;
            spr_cnt_reg  <= (state_reg == ST_SPR) ? spr_cnt_reg + 1'b1 : '0;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we && !cfg_index)
                scroll_h_reg <= cfg_data;
            if (cfg_we && cfg_index)
                scroll_v_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_RENDER)
        begin
            px_reg   <= pixel_x;
            py_reg   <= pixel_y;
            hi_v_reg <= 4'd0;
            lo_v_reg <= 4'd0;
        end
        s2_hit_reg  <= s1_valid_reg && spr_fetch.hit;
        s2_lo_reg   <= spr_fetch.lo;
        s2_prio_reg <= spr_flags[PRIORITY_BIT];
        // Sprites come highest index first, so the first opaque pixel of each class wins.
        if (s2_valid_reg && s2_hit_reg && nibble != 4'd0)
        begin
            if (s2_prio_reg && hi_v_reg == 4'd0)
                hi_v_reg <= nibble;
            if (!s2_prio_reg && lo_v_reg == 4'd0)
                lo_v_reg <= nibble;
        end
        if (state_reg == ST_BG_TILE)
        begin
            bg_hit_reg <= bg_fetch.hit && ({1'b0, bg_row} < ROW_LIMIT);
            bg_lo_reg  <= bg_fetch.lo;
        end
        if (state_reg == ST_BG_PIX)
            bg_v_reg <= bg_hit_reg ? nibble : 4'd0;
        if (state_reg == ST_PAL_RD)
            pal_drawn_reg <= (final_v != 4'd0);
        if (out_load)
        begin
            color_reg <= pal_drawn_reg ? {pal_r, pal_g, pal_b} : 24'd0;
            drawn_reg <= pal_drawn_reg;
        end
    end

    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid_reg)
        else $error("result raised during the clearing pass");

    a_undrawn_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !drawn_reg |-> color_reg == 24'd0)
        else $error("undrawn pixel carries a colour");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> state_reg == ST_SPR)
        else $error("sprite pipeline active outside the scan");

    a_render_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == CMD_RENDER |=> state_reg == ST_SPR && spr_cnt_reg == '0)
        else $error("render beat did not start the sprite scan");

endmodule

/* tb/tile_sprite_pixel_renderer_core_tb.sv */
`timescale 1ns / 1ps

module tile_sprite_pixel_renderer_core_tb;
    import tspr_pkg::*;

    localparam int HEIGHT = 240;
    localparam int SPRITES = 64;
    localparam int WATCHDOG = 60000;

    typedef struct {
        logic [23:0] color;
        logic        drawn;
    } pixel_t;

    class pixel_scoreboard;
        logic [7:0] tiles [TILE_BYTES];
        logic [7:0] names [NAME_BYTES];
        logic [7:0] sprites [SPRITE_BYTES];
        logic [7:0] palette [PALETTE_BYTES];
        logic [7:0] scroll_h;
        logic [7:0] scroll_v;
        pixel_t     pending[$];
        int         errors;

        function new();
            foreach (tiles[i]) tiles[i] = 0;
            foreach (names[i]) names[i] = 0;
            foreach (sprites[i]) sprites[i] = 0;
            foreach (palette[i]) palette[i] = 0;
            scroll_h = 0;
            scroll_v = 0;
            errors = 0;
        endfunction

        function logic [3:0] tile_px(logic [7:0] tile, logic [7:0] sx, logic [7:0] sy,
                                     logic [7:0] px, logic [7:0] py);
            int rows;
            int ty;
            logic [7:0] tx;
            int vx;
            int vy;
            int off;
            logic [7:0] b;
            if (sy >= HEIGHT) return 0;
            rows = (sy + 8 >= HEIGHT) ? HEIGHT - sy : 8;
            if (py < sy) return 0;
            ty = py - sy;
            if (ty >= rows) return 0;
            tx = px - sx;
            if (tx >= 8) return 0;
            vx = tile[4:0] * 8 + tx;
            vy = tile[7:5] * 8 + ty;
            off = (vy * 128 + vx / 2) % TILE_BYTES;
            b = tiles[off];
            return (vx % 2) ? b[3:0] : b[7:4];
        endfunction

        function logic [3:0] sprite_px(logic prio, logic [7:0] px, logic [7:0] py);
            logic [3:0] v;
            for (int i = SPRITES - 1; i >= 0; i--)
            begin
                if (sprites[i*4+3][PRIORITY_BIT] != prio) continue;
                v = tile_px(sprites[i*4], sprites[i*4+1], sprites[i*4+2], px, py);
                if (v != 0) return v;
            end
            return 0;
        endfunction

        function logic [3:0] background_px(logic [7:0] px, logic [7:0] py);
            logic [7:0] r8;
            logic [7:0] c8;
            int idx;
            logic [7:0] tile;
            r8 = py + scroll_v;
            c8 = px + scroll_h;
            if (r8[7:3] >= HEIGHT / 8) return 0;
            idx = r8[7:3] * 32 + c8[7:3];
            tile = (idx < NAME_BYTES) ? names[idx] : 8'd0;
            return tile_px(tile, 8'({c8[7:3], 3'b0} - scroll_h),
                           8'({r8[7:3], 3'b0} - scroll_v), px, py);
        endfunction

        function void note_beat(logic [2:0] c, logic [12:0] idx, logic [7:0] d,
                                logic [7:0] px, logic [7:0] py);
            logic [3:0] v;
            pixel_t p;
            case (c)
                CMD_TILE: tiles[idx] = d;
                CMD_NAME: if (idx < NAME_BYTES) names[idx] = d;
                CMD_SPRITE: if (idx < SPRITE_BYTES) sprites[idx] = d;
                CMD_PALETTE: if (idx < PALETTE_BYTES) palette[idx] = d;
                CMD_RENDER:
                begin
                    v = sprite_px(1'b1, px, py);
                    if (v == 0) v = background_px(px, py);
                    if (v == 0) v = sprite_px(1'b0, px, py);
                    p.drawn = (v != 0);
                    p.color = (v == 0) ? 24'd0 :
                        {palette[v*3], palette[v*3+1], palette[v*3+2]};
                    pending.push_back(p);
                end
                default: ;
            endcase
        endfunction

        function void check_pixel(logic [23:0] color, logic drawn);
            pixel_t p;
            if (pending.size() == 0)
            begin
                $error("unexpected pixel beat color=%h drawn=%b", color, drawn);
                errors++;
                return;
            end
            p = pending.pop_front();
            if (p.color !== color)
            begin
                $error("pixel_color expected %h actual %h", p.color, color);
                errors++;
            end
            if (p.drawn !== drawn)
            begin
                $error("drawn expected %b actual %b", p.drawn, drawn);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [2:0] cmd = 0;
    logic [12:0] store_index = 0;
    logic [7:0] store_data = 0;
    logic [7:0] pixel_x = 0;
    logic [7:0] pixel_y = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [23:0] pixel_color;
    logic drawn;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [7:0] cfg_data = 0;

    pixel_scoreboard sb = new();
    bit calm = 0;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    tile_sprite_pixel_renderer_core #(.SCREEN_HEIGHT(HEIGHT), .SPRITE_COUNT(SPRITES)) dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
        .store_index(store_index), .store_data(store_data), .pixel_x(pixel_x),
        .pixel_y(pixel_y), .out_valid(out_valid), .out_stall(out_stall),
        .pixel_color(pixel_color), .drawn(drawn), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_pixel(pixel_color, drawn);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || in_stall === 1'b0
            && !in_valid && sb.pending.size() == 0)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("tile_sprite_pixel_renderer_core_tb NOT OK");
            $finish;
        end
    end

    // Receiver back-pressure in random bursts.
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 15);
                out_stall <= 1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 0;
        end
    end

    // Valid stays high from one beat to the next unless an idle burst or a scroll write comes between.
    task automatic send_beat(logic [2:0] c, logic [12:0] idx, logic [7:0] d,
                             logic [7:0] px, logic [7:0] py);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        cmd <= c;
        store_index <= idx;
        store_data <= d;
        pixel_x <= px;
        pixel_y <= py;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_beat(c, idx, d, px, py);
        @(negedge clk);
    endtask

    task automatic write_scroll(logic h_or_v, logic [7:0] value);
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        cfg_we <= 1;
        cfg_index <= h_or_v;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 0;
        if (h_or_v) sb.scroll_v = value; else sb.scroll_h = value;
    endtask

    task automatic random_beat();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40)
            send_beat(CMD_RENDER, 13'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom_range(0, 255)));
        else if (k < 55)
            send_beat(CMD_SPRITE, 13'($urandom_range(0, 260)), 8'($urandom),
                      8'($urandom), 8'($urandom));
        else if (k < 70)
            send_beat(CMD_TILE, 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else if (k < 82)
            send_beat(CMD_NAME, 13'($urandom_range(0, 1000)), 8'($urandom),
                      8'($urandom), 8'($urandom));
        else if (k < 94)
            send_beat(CMD_PALETTE, 13'($urandom_range(0, 50)), 8'($urandom),
                      8'($urandom), 8'($urandom));
        else if (k < 97)
            send_beat(3'($urandom_range(5, 7)), 13'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
        else
            send_beat(CMD_TILE, 13'h1fff, 8'hff, 8'hff, 8'hff);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1;
        write_scroll(0, 0);
        write_scroll(1, 0);
        // Render with empty stores, then at the extremes.
        send_beat(CMD_RENDER, 0, 0, 0, 0);
        send_beat(CMD_PALETTE, 3, 8'hff, 0, 0);
        send_beat(CMD_PALETTE, 47, 8'hff, 0, 0);
        send_beat(CMD_PALETTE, 48, 8'h55, 0, 0);
        send_beat(CMD_TILE, 0, 8'h1f, 0, 0);
        send_beat(CMD_NAME, 0, 0, 0, 0);
        send_beat(CMD_NAME, 959, 8'hff, 0, 0);
        send_beat(CMD_NAME, 960, 8'h01, 0, 0);
        send_beat(CMD_TILE, 13'h1fff, 8'hf1, 0, 0);
        send_beat(CMD_RENDER, 0, 0, 0, 0);
        send_beat(CMD_RENDER, 0, 0, 1, 0);
        send_beat(CMD_RENDER, 0, 0, 255, 239);
        send_beat(CMD_RENDER, 0, 0, 255, 240);
        send_beat(CMD_RENDER, 0, 0, 255, 255);
        // A priority sprite near the bottom that wraps in x.
        send_beat(CMD_SPRITE, 252, 8'h00, 0, 0);
        send_beat(CMD_SPRITE, 253, 8'hfc, 0, 0);
        send_beat(CMD_SPRITE, 254, 8'd236, 0, 0);
        send_beat(CMD_SPRITE, 255, 8'hff, 0, 0);
        send_beat(CMD_SPRITE, 256, 8'h11, 0, 0);
        send_beat(CMD_RENDER, 0, 0, 8'hfc, 8'd236);
        send_beat(CMD_RENDER, 0, 0, 8'h02, 8'd239);
        send_beat(5, 0, 0, 0, 0);
        send_beat(7, 13'h1fff, 8'hff, 8'hff, 8'hff);
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1: begin write_scroll(0, 255); write_scroll(1, 255); end
                2: begin write_scroll(0, 8'($urandom)); write_scroll(1, 8'($urandom)); end
                3: begin write_scroll(0, 7); write_scroll(1, 16); end
                4: begin write_scroll(0, 8'($urandom)); write_scroll(1, 8'($urandom)); end
                5: begin write_scroll(0, 0); write_scroll(1, 0); calm = 1; end
                default: ;
            endcase
            for (int i = 0; i < 170; i++) random_beat();
        end
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tile_sprite_pixel_renderer_core_tb OK");
        else
            $display("tile_sprite_pixel_renderer_core_tb NOT OK");
        $finish;
    end
endmodule
